### rtl/step_rate_timer_divider_assert.svh
// Assertion macros used by the step rate timer divider sequencer.
`ifndef STEP_RATE_TIMER_DIVIDER_ASSERT_SVH
`define STEP_RATE_TIMER_DIVIDER_ASSERT_SVH
`ifndef ASSERT_OFF
// Check on every clk edge outside reset.
`define SRTD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check on every clk edge, reset included.
`define SRTD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SRTD_ASSERT(label, prop, msg)
`define SRTD_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

### rtl/srtd_pkg.sv
// Types and constants of the step rate timer divider.
`timescale 1ns / 1ps
package srtd_pkg;

  localparam int unsigned DIVIDEND_W = 32;
  localparam int unsigned DIVISOR_W  = 34;
  localparam int unsigned RATE_W     = 16;
  localparam int unsigned FIELD_W    = 16;
  localparam int unsigned CNT_MAX_W  = 16;
  localparam logic [31:0] CLK_HZ_RESET = 32'd8000000;

  typedef enum logic [1:0] {
    STAT_RUNNING   = 2'd0,
    STAT_STOPPED   = 2'd1,
    STAT_TOO_FAST  = 2'd2,
    STAT_PSC_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_CHECK,
    SQ_DIV_PSC,
    SQ_MUL,
    SQ_DIV_REL,
    SQ_DONE
  } seq_state_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic                  busy;
    logic                  done;
    logic [DIVIDEND_W-1:0] quotient;
  } div_rsp_t;

endpackage

### rtl/srtd_cfg_if.sv
// Configuration write channel of the step rate timer divider.
`timescale 1ns / 1ps
interface srtd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] timer_clock_hz;
  modport source (output valid, timer_clock_hz, input ready);
  modport sink (input valid, timer_clock_hz, output ready);
endinterface

### rtl/srtd_in_if.sv
// Step rate input channel of the step rate timer divider.
`timescale 1ns / 1ps
interface srtd_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] step_rate;
  modport source (output valid, step_rate, input ready);
  modport sink (input valid, step_rate, output ready);
endinterface

### rtl/srtd_out_if.sv
// Timer settings result channel of the step rate timer divider.
`timescale 1ns / 1ps
interface srtd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] prescaler;
  logic [15:0] reload;
  logic [14:0] compare;
  modport source (output valid, status, prescaler, reload, compare, input ready);
  modport sink (input valid, status, prescaler, reload, compare, output ready);
endinterface

### rtl/srtd_divider.sv
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module srtd_divider
  import srtd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      cnt;
  logic [DIVIDEND_W-1:0] rem;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVISOR_W-1:0]  div_q;

  logic [DIVIDEND_W:0]   trial;
  logic [DIVIDEND_W:0]   diff;
  logic                  fits;
  logic [DIVIDEND_W-1:0] rem_next;

  // Shift in the next dividend bit and subtract where the divisor fits.
  always_comb begin
    trial    = {rem, quo[DIVIDEND_W-1]};
    fits     = {{(DIVISOR_W-DIVIDEND_W-1){1'b0}}, trial} >= div_q;
    diff     = trial - div_q[DIVIDEND_W:0];
    rem_next = fits ? diff[DIVIDEND_W-1:0] : trial[DIVIDEND_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIVIDEND_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      rem   <= '0;
      quo   <= req.dividend;
      div_q <= req.divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= {quo[DIVIDEND_W-2:0], fits};
    end
  end

  assign rsp.busy     = busy;
  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

### rtl/srtd_seq.sv
// Sequencer: range checks, prescaler and reload divisions, result register.
`timescale 1ns / 1ps
`include "step_rate_timer_divider_assert.svh"
module srtd_seq
  import srtd_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [31:0]       clk_hz,
  srtd_in_if.sink           step,
  srtd_out_if.source        result,
  output div_req_t          div_req,
  input  div_rsp_t          div_rsp
);

  // Counter width used for the reload, capped at the reload field width.
  localparam int unsigned EFF_W =
    (COUNTER_WIDTH > CNT_MAX_W) ? CNT_MAX_W : COUNTER_WIDTH;

  seq_state_t state;
  seq_state_t state_next;

  logic [RATE_W-1:0]  rate;
  logic [FIELD_W-1:0] psc;
  logic [FIELD_W-1:0] rel;
  status_t            stat;

  logic               out_valid;
  status_t            out_status;
  logic [FIELD_W-1:0] out_psc;
  logic [FIELD_W-1:0] out_rel;

  logic                 rate_zero;
  logic                 too_fast;
  logic                 psc_big;
  logic                 out_load;
  logic [DIVISOR_W-1:0] div_psc;
  logic [FIELD_W:0]     psc_inc;
  logic [DIVISOR_W-2:0] prod;

  always_comb begin
    rate_zero = (rate == '0);
    too_fast  = ({{(32-RATE_W){1'b0}}, rate} > clk_hz);
    psc_big   = |div_rsp.quotient[DIVIDEND_W-1:FIELD_W];
    // (2^W + 1) * rate as a shift and an add.
    div_psc   = ({{(DIVISOR_W-RATE_W){1'b0}}, rate} << EFF_W)
              + {{(DIVISOR_W-RATE_W){1'b0}}, rate};
    psc_inc   = {1'b0, psc} + {{FIELD_W{1'b0}}, 1'b1};
    prod      = {{(DIVISOR_W-FIELD_W-2){1'b0}}, psc_inc}
              * {{(DIVISOR_W-RATE_W-1){1'b0}}, rate};
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      SQ_IDLE: begin
        if (step.valid) state_next = SQ_CHECK;
      end
      SQ_CHECK: begin
        state_next = (rate_zero || too_fast) ? SQ_DONE : SQ_DIV_PSC;
      end
      SQ_DIV_PSC: begin
        if (div_rsp.done) state_next = psc_big ? SQ_DONE : SQ_MUL;
      end
      SQ_MUL: begin
        state_next = SQ_DIV_REL;
      end
      SQ_DIV_REL: begin
        if (div_rsp.done) state_next = SQ_DONE;
      end
      SQ_DONE: begin
        if (!out_valid || result.ready) state_next = SQ_IDLE;
      end
      default: state_next = SQ_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    step.ready       = (state == SQ_IDLE);
    div_req.start    = ((state == SQ_CHECK) && !rate_zero && !too_fast) ||
                       (state == SQ_MUL);
    div_req.dividend = clk_hz;
    div_req.divisor  = (state == SQ_MUL) ? {1'b0, prod} : div_psc;
    out_load         = (state == SQ_DONE) && (!out_valid || result.ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == SQ_IDLE && step.valid) begin
      rate <= step.step_rate;
    end
    if (state == SQ_CHECK) begin
      psc <= '0;
      rel <= '0;
      if (rate_zero) begin
        stat <= STAT_STOPPED;
      end else if (too_fast) begin
        stat <= STAT_TOO_FAST;
      end else begin
        stat <= STAT_RUNNING;
      end
    end
    if (state == SQ_DIV_PSC && div_rsp.done) begin
      if (psc_big) begin
        stat <= STAT_PSC_RANGE;
      end else begin
        psc <= div_rsp.quotient[FIELD_W-1:0];
      end
    end
    if (state == SQ_DIV_REL && div_rsp.done) begin
      rel <= div_rsp.quotient[FIELD_W-1:0] - {{(FIELD_W-1){1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= stat;
      out_psc    <= psc;
      out_rel    <= rel;
    end
  end

  assign result.valid     = out_valid;
  assign result.status    = out_status;
  assign result.prescaler = out_psc;
  assign result.reload    = out_rel;
  assign result.compare   = out_rel[FIELD_W-1:1];

  `SRTD_ASSERT(a_idle_div, step.ready |-> !div_rsp.busy,
    "input taken while the divider is busy")
  `SRTD_ASSERT(a_done_wait, div_rsp.done |-> (state == SQ_DIV_PSC || state == SQ_DIV_REL),
    "divider finished outside a wait state")
  `SRTD_ASSERT(a_accept_check, (step.valid && step.ready) |=> (state == SQ_CHECK),
    "accepted item did not enter the check step")
  `SRTD_ASSERT(a_fault_zero,
    (result.valid && result.status != STAT_RUNNING) |->
      (result.prescaler == '0 && result.reload == '0),
    "nonzero timer settings with a non-running status")
  `SRTD_ASSERT_ALWAYS(a_rst_clear, rst |=> (!result.valid && state == SQ_IDLE),
    "reset did not clear the sequencer")

endmodule

### rtl/step_rate_timer_divider.sv
// Step rate timer divider top level: clock register, sequencer and divider.
`timescale 1ns / 1ps
// Turns a requested step rate into 16-bit timer settings: the smallest
// prescaler p with floor(clk / ((p+1)*rate)) - 1 fitting the counter, the
// reload value, and a compare of reload/2 for a 50% duty square wave.
//
// Channels: cfg writes the timer clock in Hz (always ready); step takes one
// step_rate item; result gives status, prescaler, reload and compare.
// Division: one serial divider, one quotient bit per cycle, does both
// divisions in turn. A zero rate or a rate above the clock skips both
// divisions, an out-of-range prescaler skips the reload division. One
// item is in work at a time; step is ready again the cycle after the
// result moves into the output register.
// Reset: clock register returns to 8 MHz, sequencer and divider go idle,
// result valid drops.
// Stall: the output register holds a result until it is taken; a new item
// may be accepted meanwhile and is held at its end until the register frees.
module step_rate_timer_divider
  import srtd_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  srtd_cfg_if.sink    cfg,
  srtd_in_if.sink     step,
  srtd_out_if.source  result
);

  // Timer clock register: user writes only while block is idle; unenforced.
  logic [31:0] clk_hz;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clk_hz <= CLK_HZ_RESET;
    end else if (cfg.valid) begin
      clk_hz <= cfg.timer_clock_hz;
    end
  end

  // Sequence checks and the two divisions, hold the result for the sink.
  srtd_seq #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .clk_hz  (clk_hz),
    .step    (step),
    .result  (result),
    .div_req (div_req),
    .div_rsp (div_rsp)
  );

  // Shared divider: prescaler first, then reload.
  srtd_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

endmodule

### dv/tb.sv
// Self-checking testbench of the step rate timer divider.
`timescale 1ns / 1ps
module tb
  import srtd_pkg::*;
();

  localparam int unsigned CNT_W         = 16;
  // Cycles without any handshake before the run is declared hung. The long
  // receiver hold-off is HOLD_CYCLES, so this leaves a wide margin.
  localparam int unsigned IDLE_LIMIT    = 20000;
  localparam int unsigned HOLD_CYCLES   = 600;
  // Quiet time after the last result, to watch for stray results.
  localparam int unsigned SETTLE_CYCLES = 150;
  localparam int unsigned IDLE_PCT      = 18;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef struct packed {
    status_t     status;
    logic [15:0] prescaler;
    logic [15:0] reload;
    logic [14:0] compare;
  } timer_setting_t;

  logic clk;
  logic rst;

  srtd_cfg_if cfg ();
  srtd_in_if  step ();
  srtd_out_if result ();

  step_rate_timer_divider #(
    .COUNTER_WIDTH(CNT_W)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .step  (step),
    .result(result)
  );

  // Timer settings predicted for accepted step rates, oldest first.
  timer_setting_t pending_settings[$];
  // Our copy of the timer clock register.
  logic [31:0]    clock_hz_model = CLK_HZ_RESET;
  // Set to suppress random idling on both channels.
  bit             steady = 1'b0;
  // Bump to ask the result side for one long hold-off.
  int unsigned    hold_requests = 0;
  int unsigned    errs = 0;
  int unsigned    idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Work out the timer settings for one step rate at a given timer clock.
  // The smallest prescaler has the closed form clk / ((max_count + 2) * rate);
  // the reload is then the period quotient minus one and compare is half of it.
  function automatic timer_setting_t solve_timer(input logic [15:0] rate,
                                                 input logic [31:0] clk_hz);
    timer_setting_t  s;
    longint unsigned r;
    longint unsigned c;
    longint unsigned span;
    longint unsigned psc;
    longint unsigned period;
    int unsigned     bits;
    bits        = (CNT_W > 16) ? 16 : CNT_W;
    r           = rate;
    c           = clk_hz;
    span        = (64'd1 << bits) + 64'd1;
    s.status    = STAT_RUNNING;
    s.prescaler = '0;
    s.reload    = '0;
    s.compare   = '0;
    if (r == 0) begin
      s.status = STAT_STOPPED;
    end else if (r > c) begin
      s.status = STAT_TOO_FAST;
    end else begin
      psc = c / (span * r);
      if (psc > 64'hFFFF) begin
        s.status = STAT_PSC_RANGE;
      end else begin
        period      = c / ((psc + 1) * r) - 1;
        s.prescaler = psc[15:0];
        s.reload    = period[15:0];
        s.compare   = period[15:1];
      end
    end
    return s;
  endfunction

  // Offer one step rate and hold it until the block takes it. Valid is left
  // high on return so that a following item goes out back to back; callers
  // that pause drop it through stop_offering.
  task automatic send_rate(input logic [15:0] rate);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        step.valid <= 1'b0;
        @(posedge clk);
      end
    end
    step.valid     <= 1'b1;
    step.step_rate <= rate;
    @(posedge clk);
    while (!step.ready) @(posedge clk);
    pending_settings.push_back(solve_timer(rate, clock_hz_model));
  endtask

  task automatic stop_offering();
    step.valid <= 1'b0;
  endtask

  // Stop sending and wait until every predicted setting has come back.
  task automatic wait_settled();
    stop_offering();
    while (pending_settings.size() != 0) @(posedge clk);
  endtask

  // Write the timer clock register once the block is idle. Never call twice
  // without an item between, so cfg valid is not dropped and raised in one step.
  task automatic write_clock(input logic [31:0] hz);
    wait_settled();
    cfg.valid          <= 1'b1;
    cfg.timer_clock_hz <= hz;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    cfg.valid      <= 1'b0;
    clock_hz_model  = hz;
  endtask

  // Pick a step rate that lands on the interesting regions for this clock:
  // stop, slow rates with large prescalers, rates right around the clock,
  // and anything at all.
  function automatic logic [15:0] pick_rate(input logic [31:0] clk_hz);
    int unsigned sel;
    int unsigned lo;
    int unsigned hi;
    sel = $urandom_range(99);
    if (sel < 8) return 16'd0;
    if (sel < 30) return 16'($urandom_range(300, 1));
    if (sel < 45 && clk_hz <= 32'd65537) begin
      lo = (clk_hz > 3) ? clk_hz - 2 : 1;
      hi = (clk_hz + 2 > 65535) ? 65535 : clk_hz + 2;
      return 16'($urandom_range(hi, lo));
    end
    return 16'($urandom_range(65535, 0));
  endfunction

  // Reset clock of 8 MHz: stop, extremes, alternating bit patterns and the
  // rates on either side of the first prescaler step.
  task automatic test_reset_clock();
    send_rate(16'd0);
    send_rate(16'd1);
    send_rate(16'hFFFF);
    send_rate(16'h5555);
    send_rate(16'hAAAA);
    send_rate(16'd122);
    send_rate(16'd123);
    send_rate(16'd0);
  endtask

  // Clock extremes: rate equal to clock, just above it, the one hertz clock,
  // and the largest clock where the prescaler reaches its top.
  task automatic test_clock_edges();
    write_clock(32'd1000);
    send_rate(16'd1000);
    send_rate(16'd1001);
    send_rate(16'd999);
    write_clock(32'd1);
    send_rate(16'd1);
    send_rate(16'd2);
    send_rate(16'hFFFF);
    write_clock(32'hFFFF_FFFF);
    send_rate(16'd1);
    send_rate(16'hFFFF);
    send_rate(16'd0);
    write_clock(32'd65535);
    send_rate(16'hFFFF);
    send_rate(16'hFFFE);
    send_rate(16'd1);
  endtask

  // Hold the result side off for a long stretch while items keep coming,
  // so the output register fills and the input stalls.
  task automatic test_backpressure();
    write_clock(CLK_HZ_RESET);
    steady = 1'b1;
    hold_requests++;
    for (int i = 0; i < 6; i++) send_rate(pick_rate(clock_hz_model));
    steady = 1'b0;
  endtask

  // Send a few items, each only after the previous result has been taken.
  task automatic test_drained_pauses();
    for (int i = 0; i < 4; i++) begin
      send_rate(pick_rate(clock_hz_model));
      wait_settled();
    end
  endtask

  task automatic random_phase(input logic [31:0] hz, input int unsigned count,
                              input bit no_idle);
    write_clock(hz);
    steady = no_idle;
    for (int unsigned i = 0; i < count; i++) send_rate(pick_rate(clock_hz_model));
    steady = 1'b0;
  endtask

  // Random rates over a spread of clocks; one phase runs with no idling.
  task automatic test_random_rates();
    logic [31:0] hz;
    random_phase(CLK_HZ_RESET, 16, 1'b0);
    random_phase(32'hFFFF_FFFF, 16, 1'b0);
    random_phase(32'd1, 10, 1'b0);
    random_phase(32'($urandom_range(131072, 1)), 16, 1'b0);
    random_phase(32'($urandom_range(70000, 2)), 16, 1'b0);
    hz = $urandom;
    if (hz == 0) hz = 32'd1;
    random_phase(hz, 24, 1'b1);
    random_phase(32'd16_000_000, 12, 1'b0);
  endtask

  // Result side ready: random idling, plus a long hold-off on request that is
  // counted down here.
  initial begin : drive_result_ready
    int unsigned stall_left;
    int unsigned holds_seen;
    stall_left   = 0;
    holds_seen   = 0;
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        result.ready <= 1'b0;
      end else begin
        result.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Compare every taken result with the oldest predicted setting.
  always @(posedge clk) begin : check_results
    timer_setting_t want;
    if (!rst && result.valid && result.ready) begin
      if (pending_settings.size() == 0) begin
        errs++;
        if (errs <= MAX_REPORTS)
          $display("%0t: unexpected result status=%0d psc=%0d reload=%0d cmp=%0d",
                   $realtime, result.status, result.prescaler, result.reload,
                   result.compare);
      end else begin
        want = pending_settings.pop_front();
        if (result.status !== want.status || result.prescaler !== want.prescaler ||
            result.reload !== want.reload || result.compare !== want.compare) begin
          errs++;
          if (errs <= MAX_REPORTS)
            $display("%0t: exp st/psc/rel/cmp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     $realtime, want.status, want.prescaler, want.reload, want.compare,
                     result.status, result.prescaler, result.reload, result.compare);
        end
      end
    end
  end

  // Watchdog: end the run if no channel moves an item for too long.
  always @(posedge clk) begin
    if (rst || (step.valid && step.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst                <= 1'b1;
    step.valid         <= 1'b0;
    step.step_rate     <= '0;
    cfg.valid          <= 1'b0;
    cfg.timer_clock_hz <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_clock();
    test_clock_edges();
    test_backpressure();
    test_drained_pauses();
    test_random_rates();

    // Drain, then watch for stray results.
    wait_settled();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errs == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
